// ===== rtl/working_day_counter_assert.svh =====
// ----------------------------------------------------------------------------
// working_day_counter_assert
// Assertion helpers for the working-day counter RTL.
// ----------------------------------------------------------------------------
`ifndef WORKING_DAY_COUNTER_ASSERT_SVH
`define WORKING_DAY_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define WDC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wdc_pkg.sv =====
// ----------------------------------------------------------------------------
// wdc_pkg
// Types, datapath operation codes and calendar constants for the
// working-day counter.
// ----------------------------------------------------------------------------
package wdc_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned COUNT_W = 22;
   localparam int unsigned MASK_W  = 7;
   localparam int unsigned OP_W    = 4;

   localparam logic [MASK_W-1:0] WEEKEND_RESET = 7'd96;

   localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

   // floor(x/25) = (x*CENT_MUL) >> 16 for x < 2500
   localparam logic [11:0] CENT_MUL = 12'd2622;
   // floor(x/7) = (x*DIV7_MUL) >> 25 for x < 2^22
   localparam logic [22:0] DIV7_MUL = 23'd4793491;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
   localparam logic [OP_W-1:0] OP_CENT  = 4'd1;
   localparam logic [OP_W-1:0] OP_LEAP  = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
   localparam logic [OP_W-1:0] OP_SUM   = 4'd4;
   localparam logic [OP_W-1:0] OP_SPAN  = 4'd5;
   localparam logic [OP_W-1:0] OP_DIVQ  = 4'd6;
   localparam logic [OP_W-1:0] OP_DIVR  = 4'd7;
   localparam logic [OP_W-1:0] OP_COUNT = 4'd8;

   typedef struct packed {
      logic            load;  // capture request beat
      logic            emit;  // move count to result register
      logic [OP_W-1:0] op;
      logic            sel;   // 0: start date / weekday, 1: end date / span
   } cmd_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // days before shifted month mm (March is 0)
   function automatic logic [8:0] march_days(input logic [MONTH_W-1:0] mm);
      logic [8:0] days;
      unique case (mm)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== rtl/wdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// wdc_ctrl
// Sequencer: steps the datapath through both date serials, the two
// divide-by-7 passes and the final count, then hands off to the result
// register.
// ----------------------------------------------------------------------------
module wdc_ctrl
   import wdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CENT  = 4'd1;
   localparam logic [3:0] ST_LEAP  = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_SUM   = 4'd4;
   localparam logic [3:0] ST_SPAN  = 4'd5;
   localparam logic [3:0] ST_DIVQ  = 4'd6;
   localparam logic [3:0] ST_DIVR  = 4'd7;
   localparam logic [3:0] ST_COUNT = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       emit;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign emit      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd.load = accept;
      cmd.emit = emit;
      cmd.sel  = sel_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CENT;
               sel_in   = 1'b0;
            end
         end
         ST_CENT: begin
            cmd.op   = OP_CENT;
            state_in = ST_LEAP;
         end
         ST_LEAP: begin
            cmd.op   = OP_LEAP;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op = OP_SUM;
            if (sel_ff) begin
               state_in = ST_SPAN;
               sel_in   = 1'b0;
            end else begin
               state_in = ST_CENT;
               sel_in   = 1'b1;
            end
         end
         ST_SPAN: begin
            cmd.op   = OP_SPAN;
            state_in = ST_DIVQ;
         end
         ST_DIVQ: begin
            cmd.op   = OP_DIVQ;
            state_in = ST_DIVR;
         end
         ST_DIVR: begin
            cmd.op = OP_DIVR;
            if (sel_ff) begin
               state_in = ST_COUNT;
            end else begin
               state_in = ST_DIVQ;
               sel_in   = 1'b1;
            end
         end
         ST_COUNT: begin
            cmd.op   = OP_COUNT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/wdc_dpath.sv =====
// ----------------------------------------------------------------------------
// wdc_dpath
// Date clamp, day serial numbers, shared divide-by-7 unit and the
// closed-form count of open weekdays. Holds the weekend mask register.
// ----------------------------------------------------------------------------
module wdc_dpath
   import wdc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               csr_wr_en,
   input  logic [MASK_W-1:0]  csr_wr_data,
   input  logic [DAY_W-1:0]   req_start_day,
   input  logic [MONTH_W-1:0] req_start_month,
   input  logic [YEAR_W-1:0]  req_start_year,
   input  logic [DAY_W-1:0]   req_end_day,
   input  logic [MONTH_W-1:0] req_end_month,
   input  logic [YEAR_W-1:0]  req_end_year,
   output logic [COUNT_W-1:0] rsp_working_days
);

   logic [MASK_W-1:0]  mask_ff;

   logic [DAY_W-1:0]   sd_ff, ed_ff;
   logic [MONTH_W-1:0] sm_ff, em_ff, sm_in, em_in;
   logic [YEAR_W-1:0]  sy_ff, ey_ff, sy_in, ey_in;

   logic [DAY_W-1:0]   d_cur;
   logic [MONTH_W-1:0] m_cur;
   logic [YEAR_W-1:0]  y_cur;
   logic               early;

   logic [6:0]         cy_ff, cy_in, cyy_ff, cyy_in;
   logic [23:0]        cprod, cyprod;
   logic [YEAR_W-1:0]  yy_ff, yy_in;
   logic [YEAR_W-1:0]  hund;
   logic               leap;
   logic [DAY_W-1:0]   len;
   logic [DAY_W-1:0]   dc_ff, dc_in;
   logic [COUNT_W-1:0] p_ff, p_in;
   logic [MONTH_W-1:0] mm;
   logic [COUNT_W-1:0] serial;
   logic [COUNT_W-1:0] sa_ff, sb_ff;

   logic               before_ff;
   logic [COUNT_W-1:0] span_ff;

   logic [COUNT_W-1:0] dx_in, dx_ff;
   logic [44:0]        qprod;
   logic [19:0]        q_ff;
   logic [COUNT_W-1:0] q7;
   logic [2:0]         r7;
   logic [2:0]         wd_ff, rem_ff;
   logic [19:0]        weeks_ff;

   logic [MASK_W-1:0]  open;
   logic [2:0]         per_week;
   logic [2:0]         extra;
   logic [22:0]        wprod;
   logic [COUNT_W-1:0] cnt_in, cnt_ff;
   logic [COUNT_W-1:0] res_ff;

   // request clamp
   always_comb begin
      sy_in = (req_start_year == '0) ? YEAR_MIN :
              (req_start_year > YEAR_MAX) ? YEAR_MAX : req_start_year;
      ey_in = (req_end_year == '0) ? YEAR_MIN :
              (req_end_year > YEAR_MAX) ? YEAR_MAX : req_end_year;
      sm_in = (req_start_month == '0) ? MONTH_MIN :
              (req_start_month > MONTH_MAX) ? MONTH_MAX : req_start_month;
      em_in = (req_end_month == '0) ? MONTH_MIN :
              (req_end_month > MONTH_MAX) ? MONTH_MAX : req_end_month;
   end

   assign d_cur = cmd.sel ? ed_ff : sd_ff;
   assign m_cur = cmd.sel ? em_ff : sm_ff;
   assign y_cur = cmd.sel ? ey_ff : sy_ff;
   assign early = (m_cur <= 4'd2);

   // century of the year and of the March-based year: (x>>2)/25
   assign cprod  = 24'(y_cur[YEAR_W-1:2]) * 24'(CENT_MUL);
   assign cy_in  = cprod[22:16];
   assign yy_in  = y_cur - YEAR_W'(early);
   assign cyprod = 24'(yy_ff[YEAR_W-1:2]) * 24'(CENT_MUL);
   assign cyy_in = cyprod[22:16];

   // leap year and day clamp
   always_comb begin
      hund  = (YEAR_W'(cy_ff) << 6) + (YEAR_W'(cy_ff) << 5) + (YEAR_W'(cy_ff) << 2);
      leap  = (y_cur == hund) ? (cy_ff[1:0] == 2'b00) : (y_cur[1:0] == 2'b00);
      len   = month_days(m_cur, leap);
      dc_in = (d_cur == '0) ? 5'd1 : (d_cur > len) ? len : d_cur;
   end

   assign p_in = COUNT_W'(yy_ff) * 22'd365;

   always_comb begin
      mm     = early ? (m_cur + 4'd9) : (m_cur - 4'd3);
      serial = p_ff + COUNT_W'(yy_ff[YEAR_W-1:2]) - COUNT_W'(cyy_ff)
             + COUNT_W'(cyy_ff[6:2]) + COUNT_W'(march_days(mm)) + COUNT_W'(dc_ff);
   end

   // shared divide by 7: weekday = (serial + 2) mod 7, then span / 7
   assign dx_in = cmd.sel ? span_ff : (sa_ff + 22'd2);
   assign qprod = 45'(dx_in) * 45'(DIV7_MUL);
   assign q7    = COUNT_W'({q_ff, 3'b000} - {3'b000, q_ff});
   assign r7    = 3'(dx_ff - q7);

   // open days in whole weeks plus the partial week from the start weekday
   always_comb begin
      logic [3:0] idx;
      logic [2:0] pw;
      logic [2:0] ex;
      pw = '0;
      ex = '0;
      open = ~mask_ff;
      for (int i = 0; i < MASK_W; i++) begin
         pw  = pw + 3'(open[i]);
         idx = 4'(wd_ff) + 4'(i);
         if (idx >= 4'd7) begin
            idx = idx - 4'd7;
         end
         if (3'(i) < rem_ff) begin
            ex = ex + 3'(open[idx[2:0]]);
         end
      end
      per_week = pw;
      extra    = ex;
      wprod    = 23'(weeks_ff) * 23'(per_week);
      cnt_in   = before_ff ? (wprod[COUNT_W-1:0] + COUNT_W'(extra)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= WEEKEND_RESET;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sd_ff <= req_start_day;
         ed_ff <= req_end_day;
         sm_ff <= sm_in;
         em_ff <= em_in;
         sy_ff <= sy_in;
         ey_ff <= ey_in;
      end
      if (cmd.emit) begin
         res_ff <= cnt_ff;
      end
      unique case (cmd.op)
         OP_CENT: begin
            cy_ff <= cy_in;
            yy_ff <= yy_in;
         end
         OP_LEAP: begin
            dc_ff  <= dc_in;
            cyy_ff <= cyy_in;
         end
         OP_MUL: begin
            p_ff <= p_in;
         end
         OP_SUM: begin
            if (cmd.sel) begin
               sb_ff <= serial;
            end else begin
               sa_ff <= serial;
            end
         end
         OP_SPAN: begin
            before_ff <= (sa_ff < sb_ff);
            span_ff   <= sb_ff - sa_ff;
         end
         OP_DIVQ: begin
            dx_ff <= dx_in;
            q_ff  <= qprod[44:25];
         end
         OP_DIVR: begin
            if (cmd.sel) begin
               weeks_ff <= q_ff;
               rem_ff   <= r7;
            end else begin
               wd_ff <= r7;
            end
         end
         OP_COUNT: begin
            cnt_ff <= cnt_in;
         end
         default: begin
         end
      endcase
   end

   assign rsp_working_days = res_ff;

endmodule

// ===== rtl/working_day_counter.sv =====
// ----------------------------------------------------------------------------
// working_day_counter: open weekdays in [start, end) by closed form
// One item at a time: new requests stall while the shared serial/divide
// sequencer is busy, until the count reaches the result register.
// Reset: synchronous active high; clears control, mask returns to Fri+Sat.
// ----------------------------------------------------------------------------
`include "working_day_counter_assert.svh"

module working_day_counter
   import wdc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [DAY_W-1:0]   req_start_day,
   input  logic [MONTH_W-1:0] req_start_month,
   input  logic [YEAR_W-1:0]  req_start_year,
   input  logic [DAY_W-1:0]   req_end_day,
   input  logic [MONTH_W-1:0] req_end_month,
   input  logic [YEAR_W-1:0]  req_end_year,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COUNT_W-1:0] rsp_working_days,
   input  logic               csr_wr_en,
   input  logic [MASK_W-1:0]  csr_wr_data
);

   cmd_type cmd;

   wdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   wdc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_start_day    (req_start_day),
      .req_start_month  (req_start_month),
      .req_start_year   (req_start_year),
      .req_end_day      (req_end_day),
      .req_end_month    (req_end_month),
      .req_end_year     (req_end_year),
      .rsp_working_days (rsp_working_days)
   );

   // a request beat always starts a multi-cycle computation
   `WDC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "accepted beat did not start work")
   // a result only shows up at the end of a computation
   `WDC_ASSERT_IMPLIES(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result without computation")

endmodule
